// File: rtl/log_record_replay_parser_defines.svh
// assertion macros for the log record replay parser
// used by the top level only
`ifndef LOG_RECORD_REPLAY_PARSER_DEFINES_SVH
`define LOG_RECORD_REPLAY_PARSER_DEFINES_SVH
// implication checked on every clock, quiet during reset
`define LRP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lrp check failed");
// next-cycle implication
`define LRP_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lrp check failed");
`endif

// File: rtl/lrp_pkg.sv
// shared types and constants for the log record replay parser
// no dependencies
`timescale 1ns / 1ps
package lrp_pkg;
    localparam int HEADER_BYTES = 32;
    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    localparam logic [31:0] CNT_MAX = 32'hFFFFFFFF;

    typedef enum logic [2:0]
    {
        KIND_PAYLOAD = 3'd0,
        KIND_DELIVERED = 3'd1,
        KIND_DISCARDED = 3'd2,
        KIND_FILTERED = 3'd3,
        KIND_SUMMARY = 3'd4
    } kind_t;

    typedef enum logic [3:0]
    {
        ERR_NONE = 4'd0,
        ERR_MAGIC = 4'd1,
        ERR_VERSION = 4'd2,
        ERR_HDR_CRC = 4'd3,
        ERR_LENGTH = 4'd4,
        ERR_TRUNC_DATA = 4'd5,
        ERR_TRUNC_CRC = 4'd6,
        ERR_DATA_CRC = 4'd7,
        ERR_DELETE_DATA = 4'd8
    } err_t;

    localparam logic [2:0] REG_MAGIC = 3'd0;
    localparam logic [2:0] REG_VERSION = 3'd1;
    localparam logic [2:0] REG_DELETE = 3'd2;
    localparam logic [2:0] REG_MIN_SEQ = 3'd3;
    localparam logic [2:0] REG_MAX_LEN = 3'd4;

    typedef struct packed
    {
        logic [2:0] kind;
        logic [3:0] error_code;
        logic [7:0] payload_byte;
        logic [63:0] rec_seq;
        logic [63:0] rec_key;
        logic is_delete;
        logic [31:0] payload_len;
        logic [63:0] highest_seq;
        logic [31:0] recovered_count;
        logic [31:0] corrupted_count;
        logic is_last;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == CNT_MAX) ? v : v + 32'd1;
    endfunction
endpackage

// File: rtl/lrp_if.sv
// valid/ready channel interfaces for the parser
// depends on lrp_pkg
`timescale 1ns / 1ps
interface lrp_in_if;
    logic valid;
    logic ready;
    logic req_type;
    logic [7:0] log_byte;
    modport source (output valid, output req_type, output log_byte, input ready);
    modport sink (input valid, input req_type, input log_byte, output ready);
endinterface

interface lrp_out_if;
    logic valid;
    logic ready;
    lrp_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lrp_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [63:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/log_record_replay_parser.sv
// Log record replay parser. Takes one log byte (or a segment end marker) per cycle while
// ready and gives payload bytes, per-record verdicts and segment summaries. Each accepted
// item gives zero, one or two results; they are registered in a two-entry output queue
// and leave when the sink takes them. A new item is taken when the queue is empty, or
// holds one result that leaves in the same cycle, so a stream runs at one item per cycle
// while the sink keeps up; a segment end that closes an open record gives two results
// and fills the queue, holding the input off. The header and payload CRC-32C is updated
// one byte per cycle. Depends on lrp_pkg, the channel interfaces and the defines header.
`timescale 1ns / 1ps
`include "log_record_replay_parser_defines.svh"
module log_record_replay_parser
#(
    parameter int HEADER_BYTES = lrp_pkg::HEADER_BYTES
)
(
    input logic clk,
    input logic rst_n,
    lrp_in_if.sink in_ch,
    lrp_out_if.source out_ch,
    lrp_cfg_if.sink cfg
);
    typedef enum logic [1:0]
    {
        PH_HEADER,
        PH_DATA,
        PH_DCRC,
        PH_SKIP
    } phase_t;

    localparam logic [4:0] HDR_LAST = 5'(HEADER_BYTES - 1);
    localparam logic [4:0] HDR_CRC_SPAN = 5'(HEADER_BYTES - 4);

    logic [15:0] magic_word_reg;
    logic [15:0] format_version_reg;
    logic [7:0] delete_type_code_reg;
    logic [63:0] min_seq_reg;
    logic [31:0] max_payload_len_reg;

    phase_t phase_reg, phase_next;
    logic [32:0] byte_index_reg, byte_index_next;
    logic [15:0] hmagic_reg, hmagic_next;
    logic [15:0] hversion_reg, hversion_next;
    logic [7:0] rtype_reg, rtype_next;
    logic [63:0] seq_reg, seq_next;
    logic [63:0] key_reg, key_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] stored_crc_reg, stored_crc_next;
    logic [31:0] crc_reg, crc_next;
    logic stopped_reg, stopped_next;
    logic [63:0] max_seq_reg, max_seq_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;

    // output queue
    lrp_pkg::result_t q_reg [2];
    logic [1:0] cnt_reg;
    logic head_reg;

    logic in_fire;
    logic out_fire;
    logic [1:0] n_res;
    lrp_pkg::result_t res0, res1;

    assign cfg.ready = 1'b1;
    assign in_ch.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ch.ready);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign out_ch.valid = (cnt_reg != 2'd0);
    assign out_ch.data = q_reg[head_reg];
    assign out_fire = out_ch.valid && out_ch.ready;

    always_comb
    begin
        lrp_pkg::result_t r;
        lrp_pkg::result_t rv;
        logic [7:0] b;
        logic [4:0] i;
        logic [31:0] hcrc;
        logic del;
        logic emit_v;
        logic [2:0] vkind;
        logic [3:0] verr;
        logic check_final;

        phase_next = phase_reg;
        byte_index_next = byte_index_reg;
        hmagic_next = hmagic_reg;
        hversion_next = hversion_reg;
        rtype_next = rtype_reg;
        seq_next = seq_reg;
        key_next = key_reg;
        length_next = length_reg;
        stored_crc_next = stored_crc_reg;
        crc_next = crc_reg;
        stopped_next = stopped_reg;
        max_seq_next = max_seq_reg;
        good_next = good_reg;
        bad_next = bad_reg;
        n_res = 2'd0;
        res0 = '0;
        res1 = '0;
        b = in_ch.log_byte;
        i = byte_index_reg[4:0];
        hcrc = '0;
        del = 1'b0;
        emit_v = 1'b0;
        vkind = lrp_pkg::KIND_DISCARDED;
        verr = lrp_pkg::ERR_NONE;
        check_final = 1'b0;
        r = '0;
        rv = '0;

        if (in_ch.req_type)
        begin
            if (!stopped_reg && (phase_reg == PH_DATA || phase_reg == PH_DCRC))
            begin
                bad_next = lrp_pkg::sat_inc(bad_reg);
                emit_v = 1'b1;
                verr = (phase_reg == PH_DATA) ? lrp_pkg::ERR_TRUNC_DATA
                    : lrp_pkg::ERR_TRUNC_CRC;
            end
        end
        else if (!stopped_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (byte_index_reg == 33'd0)
                    begin
                        hmagic_next = '0;
                        hversion_next = '0;
                        rtype_next = '0;
                        seq_next = '0;
                        key_next = '0;
                        length_next = '0;
                        stored_crc_next = '0;
                        crc_next = lrp_pkg::crc_byte(32'hFFFFFFFF, b);
                    end
                    else if (i < HDR_CRC_SPAN)
                    begin
                        crc_next = lrp_pkg::crc_byte(crc_reg, b);
                    end
                    if (i < 5'd2)
                        hmagic_next[i[0]*8 +: 8] = b;
                    else if (i < 5'd4)
                        hversion_next[i[0]*8 +: 8] = b;
                    else if (i == 5'd4)
                        rtype_next = b;
                    else if (i >= 5'd8 && i < 5'd16)
                        seq_next[i[2:0]*8 +: 8] = b;
                    else if (i >= 5'd16 && i < 5'd24)
                        key_next[i[2:0]*8 +: 8] = b;
                    else if (i >= 5'd24 && i < HDR_CRC_SPAN)
                        length_next[i[1:0]*8 +: 8] = b;
                    else if (i >= HDR_CRC_SPAN)
                        stored_crc_next[i[1:0]*8 +: 8] = b;
                    byte_index_next = byte_index_reg + 33'd1;
                    if (i == HDR_LAST)
                    begin
                        byte_index_next = '0;
                        hcrc = crc_reg ^ 32'hFFFFFFFF;
                        if (hmagic_reg != magic_word_reg)
                        begin
                            emit_v = 1'b1;
                            verr = lrp_pkg::ERR_MAGIC;
                            stopped_next = 1'b1;
                            bad_next = lrp_pkg::sat_inc(bad_reg);
                        end
                        else if (hversion_reg != format_version_reg)
                        begin
                            emit_v = 1'b1;
                            verr = lrp_pkg::ERR_VERSION;
                            stopped_next = 1'b1;
                            bad_next = lrp_pkg::sat_inc(bad_reg);
                        end
                        else if (hcrc != stored_crc_next)
                        begin
                            emit_v = 1'b1;
                            verr = lrp_pkg::ERR_HDR_CRC;
                            bad_next = lrp_pkg::sat_inc(bad_reg);
                            phase_next = (length_reg != '0) ? PH_SKIP : PH_HEADER;
                        end
                        else if (length_reg > max_payload_len_reg)
                        begin
                            emit_v = 1'b1;
                            verr = lrp_pkg::ERR_LENGTH;
                            stopped_next = 1'b1;
                            bad_next = lrp_pkg::sat_inc(bad_reg);
                        end
                        else if (length_reg == '0)
                            check_final = 1'b1;
                        else
                        begin
                            phase_next = PH_DATA;
                            crc_next = 32'hFFFFFFFF;
                        end
                    end
                end
                PH_DATA:
                begin
                    crc_next = lrp_pkg::crc_byte(crc_reg, b);
                    n_res = 2'd1;
                    r.kind = lrp_pkg::KIND_PAYLOAD;
                    r.payload_byte = b;
                    byte_index_next = byte_index_reg + 33'd1;
                    if (byte_index_next >= {1'b0, length_reg})
                    begin
                        phase_next = PH_DCRC;
                        byte_index_next = '0;
                        stored_crc_next = '0;
                    end
                end
                PH_DCRC:
                begin
                    stored_crc_next[byte_index_reg[1:0]*8 +: 8] = b;
                    byte_index_next = byte_index_reg + 33'd1;
                    if (byte_index_reg[1:0] == 2'd3)
                    begin
                        phase_next = PH_HEADER;
                        byte_index_next = '0;
                        if ((crc_reg ^ 32'hFFFFFFFF) != stored_crc_next)
                        begin
                            emit_v = 1'b1;
                            verr = lrp_pkg::ERR_DATA_CRC;
                            bad_next = lrp_pkg::sat_inc(bad_reg);
                        end
                        else
                            check_final = 1'b1;
                    end
                end
                default:
                begin
                    byte_index_next = byte_index_reg + 33'd1;
                    if (byte_index_next >= ({1'b0, length_reg} + 33'd4))
                    begin
                        phase_next = PH_HEADER;
                        byte_index_next = '0;
                    end
                end
            endcase
        end

        if (check_final)
        begin
            phase_next = PH_HEADER;
            byte_index_next = '0;
            del = (rtype_reg == delete_type_code_reg);
            emit_v = 1'b1;
            if (del && length_reg != '0)
            begin
                verr = lrp_pkg::ERR_DELETE_DATA;
                stopped_next = 1'b1;
                bad_next = lrp_pkg::sat_inc(bad_reg);
            end
            else
            begin
                if (seq_reg > max_seq_reg)
                    max_seq_next = seq_reg;
                if (seq_reg <= min_seq_reg)
                    vkind = lrp_pkg::KIND_FILTERED;
                else
                begin
                    vkind = lrp_pkg::KIND_DELIVERED;
                    good_next = lrp_pkg::sat_inc(good_reg);
                end
            end
        end

        // record fields reflect header registers (already complete at verdict time)
        r.rec_seq = seq_reg;
        r.rec_key = key_reg;
        r.is_delete = (rtype_reg == delete_type_code_reg);
        r.payload_len = length_reg;
        rv = r;
        rv.kind = emit_v ? vkind : r.kind;
        rv.error_code = verr;
        rv.payload_byte = '0;
        rv.highest_seq = max_seq_next;
        rv.recovered_count = good_next;
        rv.corrupted_count = bad_next;
        r.highest_seq = max_seq_reg;
        r.recovered_count = good_reg;
        r.corrupted_count = bad_reg;

        if (emit_v)
        begin
            res0 = rv;
            n_res = 2'd1;
        end
        else if (n_res == 2'd1)
            res0 = r;

        if (in_ch.req_type)
        begin
            res1 = '0;
            res1.kind = lrp_pkg::KIND_SUMMARY;
            res1.highest_seq = max_seq_reg;
            res1.recovered_count = good_reg;
            res1.corrupted_count = bad_next;
            res1.is_last = 1'b1;
            if (emit_v)
                n_res = 2'd2;
            else
            begin
                res0 = res1;
                n_res = 2'd1;
            end
            phase_next = PH_HEADER;
            byte_index_next = '0;
            crc_next = 32'hFFFFFFFF;
            stopped_next = 1'b0;
            good_next = '0;
            bad_next = '0;
        end
        else
            res0.is_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_word_reg <= '0;
            format_version_reg <= 16'd1;
            delete_type_code_reg <= 8'd1;
            min_seq_reg <= '0;
            max_payload_len_reg <= 32'd67108864;
            phase_reg <= PH_HEADER;
            byte_index_reg <= '0;
            hmagic_reg <= '0;
            hversion_reg <= '0;
            rtype_reg <= '0;
            seq_reg <= '0;
            key_reg <= '0;
            length_reg <= '0;
            stored_crc_reg <= '0;
            crc_reg <= 32'hFFFFFFFF;
            stopped_reg <= 1'b0;
            max_seq_reg <= '0;
            good_reg <= '0;
            bad_reg <= '0;
            cnt_reg <= '0;
            head_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg.index)
                    lrp_pkg::REG_MAGIC: magic_word_reg <= cfg.wdata[15:0];
                    lrp_pkg::REG_VERSION: format_version_reg <= cfg.wdata[15:0];
                    lrp_pkg::REG_DELETE: delete_type_code_reg <= cfg.wdata[7:0];
                    lrp_pkg::REG_MIN_SEQ: min_seq_reg <= cfg.wdata;
                    lrp_pkg::REG_MAX_LEN: max_payload_len_reg <= cfg.wdata[31:0];
                    default: ;
                endcase
            end
            if (in_fire)
            begin
                phase_reg <= phase_next;
                byte_index_reg <= byte_index_next;
                hmagic_reg <= hmagic_next;
                hversion_reg <= hversion_next;
                rtype_reg <= rtype_next;
                seq_reg <= seq_next;
                key_reg <= key_next;
                length_reg <= length_next;
                stored_crc_reg <= stored_crc_next;
                crc_reg <= crc_next;
                stopped_reg <= stopped_next;
                max_seq_reg <= max_seq_next;
                good_reg <= good_next;
                bad_reg <= bad_next;
            end
            // queue: input only taken when free entries cover the results
            if (out_fire)
                head_reg <= ~head_reg;
            if (in_fire)
                cnt_reg <= cnt_reg + n_res - {1'b0, out_fire};
            else if (out_fire)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        logic base;
        base = head_reg ^ out_fire ^ ((cnt_reg != 2'd0) && !out_fire);
        if (in_fire && n_res != 2'd0)
            q_reg[base] <= res0;
        if (in_fire && n_res == 2'd2)
            q_reg[~base] <= res1;
    end

    `LRP_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `LRP_ASSERT_IMP(a_ready_room, clk, rst_n, in_ch.ready, (cnt_reg == 2'd0) || out_ch.ready)
    `LRP_ASSERT_NXT(a_seg_reset, clk, rst_n, in_fire && in_ch.req_type,
        (phase_reg == PH_HEADER) && !stopped_reg && (good_reg == '0))
    `LRP_ASSERT_NXT(a_stop_hold, clk, rst_n, stopped_reg && in_fire && !in_ch.req_type,
        stopped_reg)
endmodule
